// File: src/stok_pkg.sv
`timescale 1ns / 1ps
package stok_pkg;

  // Offset and run length counters
  localparam int OFFSET_WIDTH = 16;
  localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = '1;

  // Reported token fields
  localparam int TOKEN_WIDTH = 16;
  localparam int EXT_WIDTH   = (OFFSET_WIDTH > TOKEN_WIDTH) ? OFFSET_WIDTH : TOKEN_WIDTH;
  localparam logic [TOKEN_WIDTH-1:0] TOKEN_MAX = '1;

  // Result queue
  localparam int MAX_RESULTS = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);

  // Bytes with special roles
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef enum logic [3:0] {
    KIND_LPAREN,
    KIND_RPAREN,
    KIND_LBRACE,
    KIND_RBRACE,
    KIND_SQUOTE,
    KIND_DQUOTE,
    KIND_BACKTICK,
    KIND_DASH_BAR,
    KIND_BAR_DASH,
    KIND_DOT,
    KIND_EQUALS,
    KIND_NUMBER,
    KIND_SYMBOL,
    KIND_OPERATOR,
    KIND_ERROR
  } kind_t;

  typedef enum logic [1:0] {
    RUN_NONE,
    RUN_NUM,
    RUN_SYM,
    RUN_OP
  } run_t;

  typedef enum logic [1:0] {
    CMT_NONE,
    CMT_BLOCK,
    CMT_LINE
  } cmt_t;

  typedef struct packed {
    logic ws;
    logic num;
    logic sym;
    logic op;
  } class_t;

  typedef struct packed {
    logic  hit;
    kind_t kind;
  } fixed_t;

  // One token produced inside the lexer step, before saturation
  typedef struct packed {
    logic                    vld;
    kind_t                   kind;
    logic [OFFSET_WIDTH-1:0] start;
    logic [OFFSET_WIDTH-1:0] len;
  } emit_t;

  // One queued result
  typedef struct packed {
    kind_t                  kind;
    logic [TOKEN_WIDTH-1:0] start;
    logic [TOKEN_WIDTH-1:0] len;
    logic                   last;
  } token_t;

  // Byte class flags
  function automatic class_t classify(input logic [7:0] b);
    class_t c;
    c     = '0;
    c.ws  = (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
    c.num = ((b >= 8'h30) && (b <= 8'h39)) || (b == 8'h2E);
    c.sym = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A)) ||
            ((b >= 8'h30) && (b <= 8'h39)) || (b == 8'h5F);
    case (b) inside
      8'h2D, 8'h2B, 8'h26, 8'h23, 8'h40, 8'h3C, 8'h3E, 8'h5B, 8'h5D, 8'h5E,
      8'h7E, 8'h25, 8'h7C, 8'h3D, 8'h24, 8'h5C, 8'h2F, 8'h2A, 8'h3A, 8'h3F,
      8'h21, 8'h2C, 8'h2E, 8'h3B,
      8'hE2, 8'h88, 8'h86, 8'h80, 8'hA2, 8'hC3, 8'hB7, 8'h97, 8'hC2, 8'hB0:
        c.op = 1'b1;
      default: c.op = 1'b0;
    endcase
    return c;
  endfunction

  // Single-byte fixed tokens
  function automatic fixed_t fixed_kind(input logic [7:0] b);
    fixed_t f;
    f.hit = 1'b1;
    unique case (b)
      8'h28:   f.kind = KIND_LPAREN;
      8'h29:   f.kind = KIND_RPAREN;
      8'h7B:   f.kind = KIND_LBRACE;
      8'h7D:   f.kind = KIND_RBRACE;
      8'h27:   f.kind = KIND_SQUOTE;
      8'h22:   f.kind = KIND_DQUOTE;
      8'h60:   f.kind = KIND_BACKTICK;
      8'h2E:   f.kind = KIND_DOT;
      8'h3D:   f.kind = KIND_EQUALS;
      default: begin
        f.hit  = 1'b0;
        f.kind = KIND_ERROR;
      end
    endcase
    return f;
  endfunction

  function automatic kind_t run_kind(input run_t rc);
    kind_t k;
    unique case (rc)
      RUN_NUM: k = KIND_NUMBER;
      RUN_SYM: k = KIND_SYMBOL;
      default: k = KIND_OPERATOR;
    endcase
    return k;
  endfunction

  function automatic logic run_member(input run_t rc, input class_t c);
    logic m;
    unique case (rc)
      RUN_NUM: m = c.num;
      RUN_SYM: m = c.sym;
      default: m = c.op;
    endcase
    return m;
  endfunction

  // Clamp a counter value to the reported field width
  function automatic logic [TOKEN_WIDTH-1:0] sat_token(input logic [OFFSET_WIDTH-1:0] v);
    logic [EXT_WIDTH-1:0] ext;
    ext = EXT_WIDTH'(v);
    return (ext > EXT_WIDTH'(TOKEN_MAX)) ? TOKEN_MAX : ext[TOKEN_WIDTH-1:0];
  endfunction

endpackage

// File: src/source_tokenizer.sv
`timescale 1ns / 1ps
// Streaming maximal-munch lexer. Source bytes enter one per transfer on the text channel and
// tokens leave on the token channel as kind, start offset and length, with last_of_run set on
// the final token caused by a byte. A byte is registered, lexed from that register once the queue
// has room, and its zero to three tokens are written at once into a four-entry result queue, so
// the first token of a byte is offered from the queue registers after that write.
// A registered byte is lexed only while the queue holds at most one waiting token. With the
// token side always ready, a byte is taken every cycle as long as no byte yields more than one
// token; a byte with more tokens holds back the next byte until the queue drains, so token-heavy
// text runs at one token per cycle. The byte with end_of_text set flushes any open token and
// returns the lexer to its reset state, offset zero.
module source_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  output logic        text_ready,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  output logic        token_valid,
  input  logic        token_ready,
  output logic [3:0]  token_kind,
  output logic [15:0] token_start,
  output logic [15:0] token_length,
  output logic        last_of_run
);

  localparam int OW = stok_pkg::OFFSET_WIDTH;

  // Input register
  logic       stg_valid;
  logic [7:0] stg_byte;
  logic       stg_eot;

  // Lexer state
  logic [OW-1:0]      byte_offset, offset_next;
  stok_pkg::run_t     run_class, run_class_next;
  logic [OW-1:0]      run_start, run_start_next;
  logic [OW-1:0]      run_length, run_length_next;
  logic [7:0]         held_byte, held_byte_next;
  logic               held_valid, held_valid_next;
  stok_pkg::cmt_t     comment_mode, comment_next;
  logic               prior_was_star, star_next;

  // Step logic
  stok_pkg::class_t   cls;
  stok_pkg::fixed_t   fx;
  stok_pkg::emit_t    e1, e2, e3;
  stok_pkg::run_t     eff_class;
  logic [OW-1:0]      eff_len;
  logic               do_run, do_tsb;
  logic [stok_pkg::RCNT_W-1:0] res_count;
  stok_pkg::emit_t    slot [stok_pkg::MAX_RESULTS];
  stok_pkg::token_t   slot_tok [stok_pkg::MAX_RESULTS];

  // Result queue
  stok_pkg::token_t             queue [stok_pkg::QUEUE_DEPTH];
  logic [stok_pkg::QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [stok_pkg::QCNT_W-1:0]  count;
  logic                         space_ok, fire, pop;
  stok_pkg::token_t             head;

  assign space_ok   = count <= stok_pkg::QCNT_W'(stok_pkg::QUEUE_DEPTH - stok_pkg::MAX_RESULTS);
  assign fire       = stg_valid && space_ok;
  assign text_ready = !stg_valid || space_ok;

  // Load the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (text_ready) begin
      stg_valid <= text_valid;
    end
    if (text_valid && text_ready) begin
      stg_byte <= text_byte;
      stg_eot  <= end_of_text;
    end
  end

  assign cls = stok_pkg::classify(stg_byte);
  assign fx  = stok_pkg::fixed_kind(stg_byte);

  // Lex one byte against the current state
  always_comb begin
    offset_next     = byte_offset;
    run_class_next  = run_class;
    run_start_next  = run_start;
    run_length_next = run_length;
    held_byte_next  = held_byte;
    held_valid_next = held_valid;
    comment_next    = comment_mode;
    star_next       = prior_was_star;
    e1        = '0;
    e2        = '0;
    e3        = '0;
    do_run    = 1'b0;
    do_tsb    = 1'b0;
    eff_class = run_class;
    eff_len   = run_length;

    // Comments, held byte, or dispatch
    unique case (comment_mode)
      stok_pkg::CMT_BLOCK: begin
        if (prior_was_star && (stg_byte == stok_pkg::CH_SLASH)) begin
          comment_next = stok_pkg::CMT_NONE;
          star_next    = 1'b0;
        end else begin
          star_next = (stg_byte == stok_pkg::CH_STAR);
        end
      end
      stok_pkg::CMT_LINE: begin
        if (stg_byte == stok_pkg::CH_LF) begin
          comment_next = stok_pkg::CMT_NONE;
        end
      end
      default: begin
        if (held_valid) begin
          held_valid_next = 1'b0;
          held_byte_next  = '0;
          if ((held_byte == stok_pkg::CH_SLASH) && (stg_byte == stok_pkg::CH_STAR)) begin
            comment_next = stok_pkg::CMT_BLOCK;
            star_next    = 1'b1;
          end else if ((held_byte == stok_pkg::CH_SLASH) &&
                       (stg_byte == stok_pkg::CH_SLASH)) begin
            comment_next = stok_pkg::CMT_LINE;
          end else if ((held_byte == stok_pkg::CH_DASH) && (stg_byte == stok_pkg::CH_BAR)) begin
            e1 = '{1'b1, stok_pkg::KIND_DASH_BAR, run_start, OW'(2)};
          end else if ((held_byte == stok_pkg::CH_BAR) && (stg_byte == stok_pkg::CH_DASH)) begin
            e1 = '{1'b1, stok_pkg::KIND_BAR_DASH, run_start, OW'(2)};
          end else begin
            // held byte becomes a one-byte operator run
            do_run    = 1'b1;
            eff_class = stok_pkg::RUN_OP;
            eff_len   = OW'(1);
          end
        end else if (run_class != stok_pkg::RUN_NONE) begin
          do_run = 1'b1;
        end else begin
          do_tsb = 1'b1;
        end
      end
    endcase

    // Extend or close the open run
    if (do_run) begin
      run_class_next = eff_class;
      if (stok_pkg::run_member(eff_class, cls)) begin
        run_length_next = (eff_len != stok_pkg::OFFSET_MAX) ? eff_len + OW'(1) : eff_len;
      end else begin
        e1              = '{1'b1, stok_pkg::run_kind(eff_class), run_start, eff_len};
        run_class_next  = stok_pkg::RUN_NONE;
        run_length_next = eff_len;
        do_tsb          = 1'b1;
      end
    end

    // Start a new token at this byte
    if (do_tsb && !cls.ws) begin
      if ((stg_byte == stok_pkg::CH_SLASH) || (stg_byte == stok_pkg::CH_DASH) ||
          (stg_byte == stok_pkg::CH_BAR)) begin
        held_valid_next = 1'b1;
        held_byte_next  = stg_byte;
        run_start_next  = byte_offset;
      end else if (fx.hit) begin
        e2 = '{1'b1, fx.kind, byte_offset, OW'(1)};
      end else if (cls.num || cls.sym || cls.op) begin
        run_class_next  = cls.num ? stok_pkg::RUN_NUM :
                          cls.sym ? stok_pkg::RUN_SYM : stok_pkg::RUN_OP;
        run_start_next  = byte_offset;
        run_length_next = OW'(1);
      end else begin
        e2 = '{1'b1, stok_pkg::KIND_ERROR, byte_offset, OW'(1)};
      end
    end

    if (byte_offset != stok_pkg::OFFSET_MAX) begin
      offset_next = byte_offset + OW'(1);
    end

    // Flush at end of text and return to reset
    if (stg_eot) begin
      if (held_valid_next) begin
        e3 = '{1'b1, stok_pkg::KIND_OPERATOR, run_start_next, OW'(1)};
      end else if (run_class_next != stok_pkg::RUN_NONE) begin
        e3 = '{1'b1, stok_pkg::run_kind(run_class_next), run_start_next, run_length_next};
      end
      offset_next     = '0;
      run_class_next  = stok_pkg::RUN_NONE;
      run_start_next  = '0;
      run_length_next = '0;
      held_byte_next  = '0;
      held_valid_next = 1'b0;
      comment_next    = stok_pkg::CMT_NONE;
      star_next       = 1'b0;
    end
  end

  // Pack the produced tokens in order
  always_comb begin
    res_count = stok_pkg::RCNT_W'(e1.vld) + stok_pkg::RCNT_W'(e2.vld) +
                stok_pkg::RCNT_W'(e3.vld);
    slot[0] = e1.vld ? e1 : (e2.vld ? e2 : e3);
    slot[1] = e1.vld ? (e2.vld ? e2 : e3) : e3;
    slot[2] = e3;
    for (int i = 0; i < stok_pkg::MAX_RESULTS; i++) begin
      slot_tok[i].kind  = slot[i].kind;
      slot_tok[i].start = stok_pkg::sat_token(slot[i].start);
      slot_tok[i].len   = stok_pkg::sat_token(slot[i].len);
      slot_tok[i].last  = (stok_pkg::RCNT_W'(i + 1) == res_count);
    end
  end

  // Advance lexer state on each processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset    <= '0;
      run_class      <= stok_pkg::RUN_NONE;
      run_start      <= '0;
      run_length     <= '0;
      held_byte      <= '0;
      held_valid     <= 1'b0;
      comment_mode   <= stok_pkg::CMT_NONE;
      prior_was_star <= 1'b0;
    end else if (fire) begin
      byte_offset    <= offset_next;
      run_class      <= run_class_next;
      run_start      <= run_start_next;
      run_length     <= run_length_next;
      held_byte      <= held_byte_next;
      held_valid     <= held_valid_next;
      comment_mode   <= comment_next;
      prior_was_star <= star_next;
    end
  end

  // Result queue: write up to three, drain one per transfer
  assign head        = queue[rd_ptr];
  assign token_valid = (count != '0);
  assign pop         = token_valid && token_ready;

  always_ff @(posedge clk) begin
    for (int i = 0; i < stok_pkg::MAX_RESULTS; i++) begin
      if (fire && (stok_pkg::RCNT_W'(i) < res_count)) begin
        queue[wr_ptr + stok_pkg::QPTR_W'(i)] <= slot_tok[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (fire) begin
        wr_ptr <= wr_ptr + stok_pkg::QPTR_W'(res_count);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + stok_pkg::QPTR_W'(1);
      end
      count <= count + (fire ? stok_pkg::QCNT_W'(res_count) : '0) -
               stok_pkg::QCNT_W'(pop);
    end
  end

  assign token_kind   = head.kind;
  assign token_start  = head.start;
  assign token_length = head.len;
  assign last_of_run  = head.last;

endmodule

// File: src/stok_checker.sv
`timescale 1ns / 1ps
module stok_checker (
  input logic        clk,
  input logic        rst,
  input logic        token_valid,
  input logic        token_ready,
  input logic [3:0]  token_kind,
  input logic [15:0] token_start,
  input logic [15:0] token_length,
  input logic        last_of_run
);

  // Hold a stalled token
  a_token_hold: assert property (@(posedge clk) disable iff (rst)
    token_valid && !token_ready |=> token_valid)
    else $error("token dropped while stalled");

  a_token_stable: assert property (@(posedge clk) disable iff (rst)
    token_valid && !token_ready |=>
      $stable(token_kind) && $stable(token_start) && $stable(token_length) &&
      $stable(last_of_run))
    else $error("token changed while stalled");

  // No token right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !token_valid)
    else $error("token present after reset");

  // Two-byte fixed tokens are two long, other fixed and error tokens one long
  a_fixed_len: assert property (@(posedge clk) disable iff (rst)
    token_valid && ((token_kind == 4'(stok_pkg::KIND_DASH_BAR)) ||
                    (token_kind == 4'(stok_pkg::KIND_BAR_DASH)))
      |-> token_length == 16'd2)
    else $error("bad length on two-byte token");

  a_single_len: assert property (@(posedge clk) disable iff (rst)
    token_valid && ((token_kind <= 4'(stok_pkg::KIND_BACKTICK)) ||
                    (token_kind == 4'(stok_pkg::KIND_DOT)) ||
                    (token_kind == 4'(stok_pkg::KIND_EQUALS)) ||
                    (token_kind == 4'(stok_pkg::KIND_ERROR)))
      |-> token_length == 16'd1)
    else $error("bad length on single-byte token");

endmodule

bind source_tokenizer stok_checker u_stok_checker (.*);
